[hw/rtl/pmct_pkg.sv]
`default_nettype none
package pmct_pkg;
    localparam int COUNT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COORD_W = 32;
    localparam int COV_W   = 48;
    localparam int HELD_W  = 16;
    localparam int DIV_W   = 66;
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic start;
        logic signed [DIV_W-1:0] dividend;
    } div_req_t;
endpackage
`default_nettype wire

[hw/rtl/pmct_divider.sv]
`default_nettype none
// floor division of a signed dividend by a positive count, one quotient bit per cycle
module pmct_divider
    import pmct_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire div_req_t                req,
    input  wire logic [COUNT_BITS-1:0]   divisor,
    output logic                         done,
    output logic signed [DIV_W-1:0]      quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]      q_reg, q_next;
    logic [COUNT_BITS:0]   r_reg, r_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next, neg_reg, neg_next, done_reg, done_next;
    logic [COUNT_BITS:0]   trial;
    logic [DIV_W-1:0]      mag;
    logic [DIV_W-1:0]      qadj;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        mag = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
        trial = {r_reg[COUNT_BITS-1:0], q_reg[DIV_W-1]};
        if (req.start) begin
            q_next = mag;
            r_next = '0;
            cnt_next = CW'(DIV_W);
            busy_next = 1'b1;
            neg_next = req.dividend[DIV_W-1];
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        neg_reg <= neg_next;
    end

    assign qadj = q_reg + DIV_W'(r_reg != '0);
    assign done = done_reg;
    assign quotient = neg_reg ? -$signed(qadj) : $signed(q_reg);
endmodule
`default_nettype wire

[hw/rtl/point_mean_covariance_tracker.sv]
`default_nettype none
// channel  dir  fields (low bit up)
// s_axis   in   tuser: kind; tdata: point_x, point_y, point_z
// m_axis   out  tuser: refused; tdata: points_held, mean_x..z, cov_xx,xy,xz,yy,yz,zz
// An update runs through accept, three mean divisions and six covariance
// steps (registered 33x33 product, then division), then the output state; all
// divisions share one serial divider (one quotient bit a cycle over 66 bits).
// A refused insert, an ignored removal or removal of the last point goes straight to output.
// s_tready is low while an item is in work or its result waits on m_tready.
// Reset (aresetn low, synchronous) clears count, mean and covariance.
module point_mean_covariance_tracker
    import pmct_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int COORD_FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // point_x, point_y, point_z
    input  wire logic         s_tuser,  // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [399:0]      m_tdata,  // points_held, mean_x,y,z, cov xx,xy,xz,yy,yz,zz
    output logic              m_tuser   // refused
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_MEAN = 3'd1, ST_MWAIT = 3'd2,
                           ST_MUL = 3'd3, ST_CWAIT = 3'd4, ST_OUT = 3'd5,
                           ST_DIVC = 3'd6;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic [2:0] st_reg, st_next;
    logic [3:0] k_reg, k_next;
    logic [COUNT_BITS-1:0] n_reg, n_next, div_reg, div_next;
    logic signed [COORD_W-1:0] mu_reg [3], mu_next [3], munew_reg [3], munew_next [3];
    logic signed [COORD_W-1:0] p_reg [3], p_next [3];
    logic signed [COV_W-1:0] c_reg [6], c_next [6];
    logic kind_reg, kind_next, ref_reg, ref_next;
    logic signed [65:0] prod_reg, prod_next;
    div_req_t req;
    logic ddone;
    logic signed [DIV_W-1:0] quo;
    logic [1:0] ai, aj;
    logic signed [32:0] dv, ev;
    logic signed [65:0] full;
    logic signed [DIV_W-1:0] s;

    pmct_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(req), .divisor(div_reg),
        .done(ddone), .quotient(quo));

    function automatic logic [1:0] axi(input logic [3:0] k);
        case (k)
            4'd0, 4'd1, 4'd2: axi = 2'd0;
            4'd3, 4'd4: axi = 2'd1;
            default: axi = 2'd2;
        endcase
    endfunction
    function automatic logic [1:0] axj(input logic [3:0] k);
        case (k)
            4'd0: axj = 2'd0;
            4'd1, 4'd3: axj = 2'd1;
            default: axj = 2'd2;
        endcase
    endfunction

    always_comb begin
        st_next = st_reg; k_next = k_reg; n_next = n_reg; div_next = div_reg;
        mu_next = mu_reg; munew_next = munew_reg; p_next = p_reg; c_next = c_reg;
        kind_next = kind_reg; ref_next = ref_reg; prod_next = prod_reg;
        req.start = 1'b0; req.dividend = '0;
        ai = axi(k_reg); aj = axj(k_reg);
        if (kind_reg == KIND_INSERT) begin
            dv = 33'(p_reg[ai]) - 33'(mu_reg[ai]);
            ev = 33'(p_reg[aj]) - 33'(munew_reg[aj]);
        end else begin
            dv = 33'(p_reg[ai]) - 33'(munew_reg[ai]);
            ev = 33'(p_reg[aj]) - 33'(mu_reg[aj]);
        end
        full = 66'(dv) * 66'(ev);
        s = '0;
        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    p_next[0] = s_tdata[31:0]; p_next[1] = s_tdata[63:32];
                    p_next[2] = s_tdata[95:64];
                    kind_next = s_tuser; ref_next = 1'b0; k_next = '0;
                    if (s_tuser == KIND_INSERT) begin
                        if (n_reg == CMAX) begin
                            ref_next = 1'b1; st_next = ST_OUT;
                        end else begin
                            div_next = n_reg + 1'b1; st_next = ST_MEAN;
                        end
                    end else if (n_reg == COUNT_BITS'(1)) begin
                        n_next = '0;
                        for (int i = 0; i < 3; i++) mu_next[i] = '0;
                        for (int i = 0; i < 6; i++) c_next[i] = '0;
                        st_next = ST_OUT;
                    end else if (n_reg == '0) begin
                        st_next = ST_OUT;
                    end else begin
                        div_next = n_reg - 1'b1; st_next = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                req.start = 1'b1;
                if (kind_reg == KIND_INSERT)
                    req.dividend = DIV_W'(p_reg[k_reg[1:0]]) - DIV_W'(mu_reg[k_reg[1:0]]);
                else
                    req.dividend = DIV_W'(mu_reg[k_reg[1:0]]) - DIV_W'(p_reg[k_reg[1:0]]);
                st_next = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (ddone) begin
                    s = DIV_W'(mu_reg[k_reg[1:0]]) + quo;
                    if (s > DIV_W'(32'sh7fffffff)) munew_next[k_reg[1:0]] = 32'sh7fffffff;
                    else if (s < -DIV_W'(33'sh080000000))
                        munew_next[k_reg[1:0]] = 32'sh80000000;
                    else munew_next[k_reg[1:0]] = s[31:0];
                    if (k_reg == 4'd2) begin
                        k_next = '0; st_next = ST_MUL;
                    end else begin
                        k_next = k_reg + 1'b1; st_next = ST_MEAN;
                    end
                end
            end
            ST_MUL: begin
                prod_next = full >>> COORD_FRAC_BITS;
                st_next = ST_DIVC;
            end
            ST_DIVC: begin
                req.start = 1'b1;
                if (kind_reg == KIND_INSERT)
                    req.dividend = DIV_W'(prod_reg) - DIV_W'(c_reg[k_reg[2:0]]);
                else
                    req.dividend = DIV_W'(c_reg[k_reg[2:0]]) - DIV_W'(prod_reg);
                st_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (ddone) begin
                    s = DIV_W'(c_reg[k_reg[2:0]]) + quo;
                    if (s > $signed(DIV_W'({1'b0, {(COV_W-1){1'b1}}})))
                        c_next[k_reg[2:0]] = {1'b0, {(COV_W-1){1'b1}}};
                    else if (s < -$signed(DIV_W'({1'b0, 1'b1, {(COV_W-1){1'b0}}})))
                        c_next[k_reg[2:0]] = {1'b1, {(COV_W-1){1'b0}}};
                    else c_next[k_reg[2:0]] = s[COV_W-1:0];
                    if (k_reg == 4'd5) begin
                        mu_next = munew_reg; n_next = div_reg; st_next = ST_OUT;
                    end else begin
                        k_next = k_reg + 1'b1; st_next = ST_MUL;
                    end
                end
            end
            ST_OUT: if (m_tready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; n_reg <= '0;
            for (int i = 0; i < 3; i++) mu_reg[i] <= '0;
            for (int i = 0; i < 6; i++) c_reg[i] <= '0;
        end else begin
            st_reg <= st_next; n_reg <= n_next; mu_reg <= mu_next; c_reg <= c_next;
        end
        k_reg <= k_next; div_reg <= div_next; munew_reg <= munew_next; p_reg <= p_next;
        kind_reg <= kind_next; ref_reg <= ref_next;
        prod_reg <= prod_next;
    end

    logic [HELD_W-1:0] held;
    always_comb begin
        if (COUNT_BITS > HELD_W && (n_reg >> HELD_W) != '0) held = '1;
        else held = HELD_W'(n_reg);
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tuser  = ref_reg;
    assign m_tdata  = {c_reg[5], c_reg[4], c_reg[3], c_reg[2], c_reg[1], c_reg[0],
                       mu_reg[2], mu_reg[1], mu_reg[0], held};
endmodule
`default_nettype wire
